[design/ethp_pkg.sv]
`default_nettype none

package ethp_pkg;

    // protocol constants
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;

    // header sizes in bytes
    localparam logic [5:0]  ETH_HDR_LEN    = 6'd14;
    localparam logic [5:0]  IP_MIN_HDR_LEN = 6'd20;
    localparam logic [5:0]  UDP_HDR_LEN    = 6'd8;

    // layer codes of a result word
    localparam logic [2:0]  LAYER_ETH      = 3'd0;
    localparam logic [2:0]  LAYER_IPV4     = 3'd1;
    localparam logic [2:0]  LAYER_TCP      = 3'd2;
    localparam logic [2:0]  LAYER_UDP      = 3'd3;
    localparam logic [2:0]  LAYER_BAD_VER  = 3'd4;

    // one result word
    typedef struct packed {
        logic [2:0]  layer;
        logic [47:0] src_id;
        logic [47:0] dst_id;
        logic [15:0] type_code;
        logic [15:0] total_length;
        logic [5:0]  hdr_len;
        logic [15:0] checksum;
        logic [31:0] tcp_seq;
        logic [31:0] tcp_ack;
        logic [15:0] id_or_window;
        logic [15:0] ttl_or_urgent;
    } t_hdr_word;

endpackage

`default_nettype wire

[design/ethp_if.sv]
`default_nettype none

// frame byte channel
interface ethp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, data_byte, frame_end, input ready);
    modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

// header result channel
interface ethp_hdr_if;
    logic        valid;
    logic        ready;
    logic [2:0]  layer;
    logic [47:0] src_id;
    logic [47:0] dst_id;
    logic [15:0] type_code;
    logic [15:0] total_length;
    logic [5:0]  hdr_len;
    logic [15:0] checksum;
    logic [31:0] tcp_seq;
    logic [31:0] tcp_ack;
    logic [15:0] id_or_window;
    logic [15:0] ttl_or_urgent;

    modport source (output valid, layer, src_id, dst_id, type_code, total_length,
                    hdr_len, checksum, tcp_seq, tcp_ack, id_or_window,
                    ttl_or_urgent, input ready);
    modport sink   (input valid, layer, src_id, dst_id, type_code, total_length,
                    hdr_len, checksum, tcp_seq, tcp_ack, id_or_window,
                    ttl_or_urgent, output ready);
endinterface

`default_nettype wire

[design/ethp_engine.sv]
`default_nettype none

module ethp_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_frame_end,
    output      logic              o_emit,
    output      ethp_pkg::t_hdr_word o_result
);

    typedef enum logic [2:0] {
        PH_ETH,
        PH_IP,
        PH_IPOPT,
        PH_TCP,
        PH_UDP,
        PH_SKIP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_count, n_count;
    logic [5:0]  r_hdr_end, n_hdr_end;
    logic [47:0] r_src, n_src;
    logic [47:0] r_dst, n_dst;
    logic [15:0] r_type, n_type;
    logic [15:0] r_len, n_len;
    logic [15:0] r_ip_pay, n_ip_pay;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_csum, n_csum;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_ack, n_ack;
    logic [15:0] r_id_win, n_id_win;
    logic [15:0] r_ttl_urg, n_ttl_urg;

    logic                emit;
    ethp_pkg::t_hdr_word res;
    logic [15:0]         hdr_end_w;
    logic [6:0]          count_inc;
    t_phase              next_l4;

    // layer 4 phase chosen by the ip protocol
    always_comb begin
        if (n_proto == ethp_pkg::PROTO_TCP) begin
            next_l4 = PH_TCP;
        end else if (n_proto == ethp_pkg::PROTO_UDP) begin
            next_l4 = PH_UDP;
        end else begin
            next_l4 = PH_SKIP;
        end
    end

    // field gathering and result building for one byte
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_hdr_end = r_hdr_end;
        n_src     = r_src;
        n_dst     = r_dst;
        n_type    = r_type;
        n_len     = r_len;
        n_ip_pay  = r_ip_pay;
        n_proto   = r_proto;
        n_csum    = r_csum;
        n_seq     = r_seq;
        n_ack     = r_ack;
        n_id_win  = r_id_win;
        n_ttl_urg = r_ttl_urg;
        emit      = 1'b0;
        res       = '0;
        hdr_end_w = {10'd0, r_hdr_end};
        count_inc = {1'b0, r_count} + 7'd1;

        case (r_phase)
            PH_ETH: begin
                if (r_count < 6'd6) begin
                    n_dst = {r_dst[39:0], i_data_byte};
                end else if (r_count < 6'd12) begin
                    n_src = {r_src[39:0], i_data_byte};
                end else begin
                    n_type = {r_type[7:0], i_data_byte};
                end
                if (r_count >= 6'd13) begin
                    emit              = 1'b1;
                    res.layer         = ethp_pkg::LAYER_ETH;
                    res.src_id        = n_src;
                    res.dst_id        = n_dst;
                    res.type_code     = n_type;
                    res.hdr_len       = ethp_pkg::ETH_HDR_LEN;
                    n_phase = (n_type == ethp_pkg::ETHERTYPE_IPV4) ? PH_IP : PH_SKIP;
                    n_count = '0;
                end else begin
                    n_count = count_inc[5:0];
                end
            end

            PH_IP: begin
                if (r_count == 6'd0 && i_data_byte[7:4] != ethp_pkg::IP_VERSION_4) begin
                    // bad version: report it and drop the frame
                    emit          = 1'b1;
                    res.layer     = ethp_pkg::LAYER_BAD_VER;
                    res.type_code = {12'd0, i_data_byte[7:4]};
                    n_phase       = PH_SKIP;
                    n_count       = '0;
                end else begin
                    case (r_count) inside
                        6'd0:           n_hdr_end = {i_data_byte[3:0], 2'b00};
                        6'd2, 6'd3:     n_len     = {r_len[7:0], i_data_byte};
                        6'd4, 6'd5:     n_id_win  = {r_id_win[7:0], i_data_byte};
                        6'd8:           n_ttl_urg = {8'd0, i_data_byte};
                        6'd9:           n_proto   = i_data_byte;
                        6'd10, 6'd11:   n_csum    = {r_csum[7:0], i_data_byte};
                        [6'd12:6'd15]:  n_src     = {r_src[39:0], i_data_byte};
                        [6'd16:6'd63]:  n_dst     = {r_dst[39:0], i_data_byte};
                        default: ;
                    endcase
                    if (r_count >= 6'd19) begin
                        // payload length saturates at zero
                        n_ip_pay = (n_len > hdr_end_w) ? (n_len - hdr_end_w) : 16'd0;
                        emit              = 1'b1;
                        res.layer         = ethp_pkg::LAYER_IPV4;
                        res.src_id        = {16'd0, n_src[31:0]};
                        res.dst_id        = {16'd0, n_dst[31:0]};
                        res.type_code     = {8'd0, n_proto};
                        res.total_length  = n_len;
                        res.hdr_len       = r_hdr_end;
                        res.checksum      = n_csum;
                        res.id_or_window  = n_id_win;
                        res.ttl_or_urgent = n_ttl_urg;
                        if (r_hdr_end > ethp_pkg::IP_MIN_HDR_LEN) begin
                            n_phase = PH_IPOPT;
                            n_count = ethp_pkg::IP_MIN_HDR_LEN;
                        end else begin
                            n_phase = next_l4;
                            n_count = '0;
                        end
                    end else begin
                        n_count = count_inc[5:0];
                    end
                end
            end

            PH_IPOPT: begin
                // skip ip options up to ihl*4
                if (count_inc >= {1'b0, r_hdr_end}) begin
                    n_phase = next_l4;
                    n_count = '0;
                end else begin
                    n_count = count_inc[5:0];
                end
            end

            PH_TCP: begin
                case (r_count) inside
                    [6'd0:6'd1]:    n_src     = {r_src[39:0], i_data_byte};
                    [6'd2:6'd3]:    n_dst     = {r_dst[39:0], i_data_byte};
                    [6'd4:6'd7]:    n_seq     = {r_seq[23:0], i_data_byte};
                    [6'd8:6'd11]:   n_ack     = {r_ack[23:0], i_data_byte};
                    6'd12:          n_hdr_end = {i_data_byte[7:4], 2'b00};
                    6'd13:          n_type    = {8'd0, i_data_byte};
                    [6'd14:6'd15]:  n_id_win  = {r_id_win[7:0], i_data_byte};
                    [6'd16:6'd17]:  n_csum    = {r_csum[7:0], i_data_byte};
                    default:        n_ttl_urg = {r_ttl_urg[7:0], i_data_byte};
                endcase
                if (r_count >= 6'd19) begin
                    emit              = 1'b1;
                    res.layer         = ethp_pkg::LAYER_TCP;
                    res.src_id        = {32'd0, n_src[15:0]};
                    res.dst_id        = {32'd0, n_dst[15:0]};
                    res.type_code     = n_type;
                    res.total_length  = (r_ip_pay > hdr_end_w) ? (r_ip_pay - hdr_end_w)
                                                               : 16'd0;
                    res.hdr_len       = r_hdr_end;
                    res.checksum      = n_csum;
                    res.tcp_seq       = n_seq;
                    res.tcp_ack       = n_ack;
                    res.id_or_window  = n_id_win;
                    res.ttl_or_urgent = n_ttl_urg;
                    n_phase = PH_SKIP;
                    n_count = '0;
                end else begin
                    n_count = count_inc[5:0];
                end
            end

            PH_UDP: begin
                case (r_count) inside
                    [6'd0:6'd1]: n_src  = {r_src[39:0], i_data_byte};
                    [6'd2:6'd3]: n_dst  = {r_dst[39:0], i_data_byte};
                    [6'd4:6'd5]: n_len  = {r_len[7:0], i_data_byte};
                    default:     n_csum = {r_csum[7:0], i_data_byte};
                endcase
                if (r_count >= 6'd7) begin
                    emit              = 1'b1;
                    res.layer         = ethp_pkg::LAYER_UDP;
                    res.src_id        = {32'd0, n_src[15:0]};
                    res.dst_id        = {32'd0, n_dst[15:0]};
                    res.type_code     = {8'd0, ethp_pkg::PROTO_UDP};
                    res.total_length  = n_len;
                    res.hdr_len       = ethp_pkg::UDP_HDR_LEN;
                    res.checksum      = n_csum;
                    n_phase = PH_SKIP;
                    n_count = '0;
                end else begin
                    n_count = count_inc[5:0];
                end
            end

            default: ;
        endcase

        // end of frame returns the parser to the ethernet header
        if (i_frame_end) begin
            n_phase   = PH_ETH;
            n_count   = '0;
            n_hdr_end = ethp_pkg::ETH_HDR_LEN;
        end
    end

    assign o_emit   = i_accept && emit;
    assign o_result = res;

    // parser state, advanced once per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ETH;
            r_count   <= '0;
            r_hdr_end <= ethp_pkg::ETH_HDR_LEN;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_hdr_end <= n_hdr_end;
        end
    end

    // gathered header fields, fully rewritten before each use
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_src     <= n_src;
            r_dst     <= n_dst;
            r_type    <= n_type;
            r_len     <= n_len;
            r_ip_pay  <= n_ip_pay;
            r_proto   <= n_proto;
            r_csum    <= n_csum;
            r_seq     <= n_seq;
            r_ack     <= n_ack;
            r_id_win  <= n_id_win;
            r_ttl_urg <= n_ttl_urg;
        end
    end

endmodule

`default_nettype wire

[design/eth_ipv4_l4_header_parser.sv]
// channel   dir  modport  word
// i_byte    in   sink     data_byte[7:0], frame_end
// o_hdr     out  source   layer, ids, type, lengths, checksum, seq/ack, id/win, ttl/urg
//
// one byte per cycle while input is not stalled: the parser state advances on
// every accepted word and a header result, if any, is registered into the main
// or skid entry at that same edge. a two-entry output stage (main + skid) keeps
// i_byte.ready registered; input stalls only when both entries hold results
// not yet taken. i_rst_n is synchronous, active low, and returns the parser
// to the ethernet header; frame_end does the same after its byte.
`default_nettype none

module eth_ipv4_l4_header_parser (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ethp_byte_if.sink   i_byte,
    ethp_hdr_if.source  o_hdr
);

    logic                in_accept;
    logic                out_take;
    logic                emit;
    ethp_pkg::t_hdr_word result;

    logic                r_out_valid;
    logic                r_skid_valid;
    ethp_pkg::t_hdr_word r_out;
    ethp_pkg::t_hdr_word r_skid;

    assign i_byte.ready = !r_skid_valid;
    assign in_accept    = i_byte.valid && !r_skid_valid;
    assign out_take     = r_out_valid && o_hdr.ready;

    // header parsing engine
    ethp_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_byte.data_byte),
        .i_frame_end (i_byte.frame_end),
        .o_emit      (emit),
        .o_result    (result)
    );

    // output stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= emit;
            end
        end else if (emit) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid  <= 1'b1;
            end
        end
    end

    // output stage words
    always_ff @(posedge i_clk) begin
        if (out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (emit) begin
                r_out <= result;
            end
        end else if (emit) begin
            if (r_out_valid) begin
                r_skid <= result;
            end else begin
                r_out  <= result;
            end
        end
    end

    // result port
    assign o_hdr.valid         = r_out_valid;
    assign o_hdr.layer         = r_out.layer;
    assign o_hdr.src_id        = r_out.src_id;
    assign o_hdr.dst_id        = r_out.dst_id;
    assign o_hdr.type_code     = r_out.type_code;
    assign o_hdr.total_length  = r_out.total_length;
    assign o_hdr.hdr_len       = r_out.hdr_len;
    assign o_hdr.checksum      = r_out.checksum;
    assign o_hdr.tcp_seq       = r_out.tcp_seq;
    assign o_hdr.tcp_ack       = r_out.tcp_ack;
    assign o_hdr.id_or_window  = r_out.id_or_window;
    assign o_hdr.ttl_or_urgent = r_out.ttl_or_urgent;

endmodule

`default_nettype wire

[design/ethp_checker.sv]
`default_nettype none

module ethp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_layer,
    input wire logic [15:0] i_type_code,
    input wire logic [5:0]  i_hdr_len
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_layer)
            && $stable(i_type_code))
        else $error("result word changed while stalled");

    // input only backs off while results are waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending result");

    // ethernet and udp words carry their fixed header sizes
    a_fixed_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_layer == ethp_pkg::LAYER_ETH || i_layer == ethp_pkg::LAYER_UDP)
            |-> i_hdr_len == ((i_layer == ethp_pkg::LAYER_ETH) ?
                ethp_pkg::ETH_HDR_LEN : ethp_pkg::UDP_HDR_LEN))
        else $error("fixed header length wrong");

    // bad version words carry no header length and never report version four
    a_bad_ver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_layer == ethp_pkg::LAYER_BAD_VER
            |-> i_hdr_len == 6'd0
                && i_type_code != {12'd0, ethp_pkg::IP_VERSION_4})
        else $error("bad version word malformed");

endmodule

bind eth_ipv4_l4_header_parser ethp_checker u_ethp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_hdr.valid),
    .i_out_ready (o_hdr.ready),
    .i_layer     (o_hdr.layer),
    .i_type_code (o_hdr.type_code),
    .i_hdr_len   (o_hdr.hdr_len)
);

`default_nettype wire
